// ===== sv/buvt_pkg.sv =====
// shared types and constants for the box union volume table
package buvt_pkg;
	localparam int MAX_BOXES = 1024;
	localparam int COORD_BITS = 18;
	localparam int ADDR_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int DIM_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIM_W;
	localparam int VOL_W = 55;
	localparam int FRAG_W = 3;
	localparam logic [FRAG_W-1:0] FRAG_LAST = FRAG_W'(5);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x0;
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y0;
		logic signed [COORD_BITS-1:0] y1;
		logic signed [COORD_BITS-1:0] z0;
		logic signed [COORD_BITS-1:0] z1;
	} box_t;

	typedef struct packed {
		logic              we;
		logic              wbank;
		logic [ADDR_W-1:0] waddr;
		logic              re;
		logic              rbank;
		logic [ADDR_W-1:0] raddr;
	} store_ctl_t;
endpackage

// ===== sv/box_union_volume_table_unit.sv =====
// top level: box table sequencer, split pass and volume pass
// Keeps a table of disjoint lit boxes in two ping-pong banks.
// Input requests arrive on s_*: tdata holds the six bounds, tuser the on/off flag.
// Each request gives one result on m_*: lit volume, box count and overflow flag.
// Split pass: every stored box is read once and its six candidate fragments are
// checked one per cycle (S_RD, then S_FR), then the input box is appended (S_APP).
// Surviving fragments go to the other bank.
// Volume pass: each box of the resulting table goes through V_RD, V_MA, V_MB, V_MC
// and V_ACC on the single 19x19 multiplier (dx*dy, then two partial products with dz).
// s_tready is low from the accepted request until its result is taken.
// If the new table would exceed the capacity, the old bank stays active and
// overflowed is set.
// Reset empties the table at once (count to zero); no clearing pass is needed.
// The result is held on m_* until taken; a stall there simply keeps the block busy.
module box_union_volume_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// x_low, x_high, y_low, y_high, z_low, z_high, zero fill
	input  logic [111:0]  s_tdata,
	// turn_on
	input  logic          s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// lit_volume, stored_boxes, zero fill
	output logic [71:0]   m_tdata,
	// overflowed
	output logic          m_tuser
);
	localparam int CB = buvt_pkg::COORD_BITS;

	typedef enum logic [3:0] {
		IDLE, S_RD, S_FR, S_APP, V_RD, V_MA, V_MB, V_MC, V_ACC, OUT
	} state_t;

	state_t state_q;
	buvt_pkg::box_t box_q;
	logic on_q, empty_q, cur_q, nover_q;
	logic [buvt_pkg::CNT_W-1:0] count_q, ncount_q, i_q;
	logic [buvt_pkg::FRAG_W-1:0] k_q;
	logic [buvt_pkg::VOL_W-1:0] vol_q;
	logic [buvt_pkg::PROD_W-1:0] dxy_q, lo_q;
	logic [buvt_pkg::VOL_W-1:0] vol_out_q;
	logic [buvt_pkg::CNT_W-1:0] cnt_out_q;
	logic over_out_q;

	buvt_pkg::store_ctl_t ctl;
	buvt_pkg::box_t rdata, wdata, frag, in_box;
	logic fvalid, emit, room, in_empty;
	logic [buvt_pkg::DIM_W-1:0] dx, dy, dz, ma, mb;
	logic [buvt_pkg::PROD_W-1:0] p;

	buvt_store u_store (.clk(clk), .ctl(ctl), .wdata(wdata), .rdata(rdata));

	buvt_frag u_frag (
		.a(rdata), .b(box_q), .empty(empty_q), .k(k_q), .valid(fvalid), .frag(frag)
	);

	buvt_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(p));

	always_comb begin
		in_box.x0 = s_tdata[CB-1:0];
		in_box.x1 = s_tdata[2*CB-1:CB];
		in_box.y0 = s_tdata[3*CB-1:2*CB];
		in_box.y1 = s_tdata[4*CB-1:3*CB];
		in_box.z0 = s_tdata[5*CB-1:4*CB];
		in_box.z1 = s_tdata[6*CB-1:5*CB];
		in_empty = (in_box.x0 > in_box.x1) || (in_box.y0 > in_box.y1)
			|| (in_box.z0 > in_box.z1);
	end

	// fragment or appended box goes to the spare bank
	assign emit = ((state_q == S_FR) && fvalid) || ((state_q == S_APP) && on_q && !empty_q);
	assign room = ncount_q < buvt_pkg::CNT_W'(buvt_pkg::MAX_BOXES);
	assign wdata = (state_q == S_APP) ? box_q : frag;

	always_comb begin
		ctl.we = emit && room;
		ctl.wbank = !cur_q;
		ctl.waddr = ncount_q[buvt_pkg::ADDR_W-1:0];
		ctl.re = ((state_q == S_RD) || (state_q == V_RD)) && (i_q < count_q);
		ctl.rbank = cur_q;
		ctl.raddr = i_q[buvt_pkg::ADDR_W-1:0];
	end

	always_comb begin
		dx = buvt_pkg::DIM_W'({rdata.x1[CB-1], rdata.x1} - {rdata.x0[CB-1], rdata.x0} + 1'b1);
		dy = buvt_pkg::DIM_W'({rdata.y1[CB-1], rdata.y1} - {rdata.y0[CB-1], rdata.y0} + 1'b1);
		dz = buvt_pkg::DIM_W'({rdata.z1[CB-1], rdata.z1} - {rdata.z0[CB-1], rdata.z0} + 1'b1);
		ma = dx;
		mb = dz;
		case (state_q)
			V_MA: mb = dy;
			V_MB: ma = p[buvt_pkg::DIM_W-1:0];
			V_MC: ma = dxy_q[buvt_pkg::PROD_W-1:buvt_pkg::DIM_W];
			default: ma = dx;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cur_q <= 1'b0;
			count_q <= '0;
			ncount_q <= '0;
			i_q <= '0;
			k_q <= '0;
			nover_q <= 1'b0;
			vol_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						box_q <= in_box;
						on_q <= s_tuser;
						empty_q <= in_empty;
						i_q <= '0;
						ncount_q <= '0;
						nover_q <= 1'b0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					k_q <= '0;
					state_q <= (i_q < count_q) ? S_FR : S_APP;
				end
				S_FR: begin
					if (emit) begin
						if (room) ncount_q <= ncount_q + 1'b1;
						else nover_q <= 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_q == buvt_pkg::FRAG_LAST) begin
						i_q <= i_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_APP: begin
					// on overflow the old bank stays the table
					if (!(nover_q || (emit && !room))) begin
						cur_q <= !cur_q;
						count_q <= ncount_q + buvt_pkg::CNT_W'(emit);
					end
					nover_q <= nover_q || (emit && !room);
					i_q <= '0;
					vol_q <= '0;
					state_q <= V_RD;
				end
				V_RD: state_q <= (i_q < count_q) ? V_MA : OUT;
				V_MA: state_q <= V_MB;
				V_MB: begin
					dxy_q <= p;
					state_q <= V_MC;
				end
				V_MC: begin
					lo_q <= p;
					state_q <= V_ACC;
				end
				V_ACC: begin
					vol_q <= vol_q + buvt_pkg::VOL_W'(lo_q)
						+ buvt_pkg::VOL_W'({p, {buvt_pkg::DIM_W{1'b0}}});
					i_q <= i_q + 1'b1;
					state_q <= V_RD;
				end
				OUT: begin
					if (m_tready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (state_q == V_RD && !(i_q < count_q)) begin
				vol_out_q <= vol_q;
				cnt_out_q <= count_q;
				over_out_q <= nover_q;
			end
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = (state_q == OUT);
	assign m_tdata = {6'b0, cnt_out_q, vol_out_q};
	assign m_tuser = over_out_q;

`ifndef SYNTH
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("request taken while result pending");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= buvt_pkg::CNT_W'(buvt_pkg::MAX_BOXES)) else $error("table over capacity");
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready) else $error("not ready after result");
	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APP) && nover_q |=> $stable(cur_q)) else $error("bank swapped on overflow");
`endif
endmodule

// ===== sv/buvt_store.sv =====
// two banks of box storage, one write and one registered read per cycle
module buvt_store (
	input  logic                clk,
	input  buvt_pkg::store_ctl_t ctl,
	input  buvt_pkg::box_t      wdata,
	output buvt_pkg::box_t      rdata
);
	buvt_pkg::box_t mem0 [buvt_pkg::MAX_BOXES];
	buvt_pkg::box_t mem1 [buvt_pkg::MAX_BOXES];
	buvt_pkg::box_t rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we && !ctl.wbank) mem0[ctl.waddr] <= wdata;
		if (ctl.we && ctl.wbank) mem1[ctl.waddr] <= wdata;
		if (ctl.re) begin
			rdata_q <= ctl.rbank ? mem1[ctl.raddr] : mem0[ctl.raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== sv/buvt_frag.sv =====
// leftover fragment k of a stored box after removing the input box
module buvt_frag (
	input  buvt_pkg::box_t                 a,
	input  buvt_pkg::box_t                 b,
	input  logic                           empty,
	input  logic [buvt_pkg::FRAG_W-1:0]    k,
	output logic                           valid,
	output buvt_pkg::box_t                 frag
);
	logic signed [buvt_pkg::COORD_BITS-1:0] ix0, ix1, iy0, iy1, iz0, iz1;
	logic overlap;

	always_comb begin
		ix0 = (a.x0 > b.x0) ? a.x0 : b.x0;
		ix1 = (a.x1 < b.x1) ? a.x1 : b.x1;
		iy0 = (a.y0 > b.y0) ? a.y0 : b.y0;
		iy1 = (a.y1 < b.y1) ? a.y1 : b.y1;
		iz0 = (a.z0 > b.z0) ? a.z0 : b.z0;
		iz1 = (a.z1 < b.z1) ? a.z1 : b.z1;
		overlap = !empty && (ix0 <= ix1) && (iy0 <= iy1) && (iz0 <= iz1);
		frag = a;
		valid = 1'b0;
		if (!overlap) begin
			valid = (k == '0);
		end else begin
			case (k)
				3'd0: begin
					valid = a.x0 < ix0;
					frag.x1 = ix0 - buvt_pkg::COORD_BITS'(1);
				end
				3'd1: begin
					valid = ix1 < a.x1;
					frag.x0 = ix1 + buvt_pkg::COORD_BITS'(1);
				end
				3'd2: begin
					valid = a.y0 < iy0;
					frag.x0 = ix0; frag.x1 = ix1;
					frag.y1 = iy0 - buvt_pkg::COORD_BITS'(1);
				end
				3'd3: begin
					valid = iy1 < a.y1;
					frag.x0 = ix0; frag.x1 = ix1;
					frag.y0 = iy1 + buvt_pkg::COORD_BITS'(1);
				end
				3'd4: begin
					valid = a.z0 < iz0;
					frag.x0 = ix0; frag.x1 = ix1;
					frag.y0 = iy0; frag.y1 = iy1;
					frag.z1 = iz0 - buvt_pkg::COORD_BITS'(1);
				end
				3'd5: begin
					valid = iz1 < a.z1;
					frag.x0 = ix0; frag.x1 = ix1;
					frag.y0 = iy0; frag.y1 = iy1;
					frag.z0 = iz1 + buvt_pkg::COORD_BITS'(1);
				end
				default: valid = 1'b0;
			endcase
		end
	end
endmodule

// ===== sv/buvt_mul.sv =====
// shared registered unsigned multiplier for the volume pass
module buvt_mul (
	input  logic                          clk,
	input  logic [buvt_pkg::DIM_W-1:0]    a,
	input  logic [buvt_pkg::DIM_W-1:0]    b,
	output logic [buvt_pkg::PROD_W-1:0]   p
);
	logic [buvt_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= buvt_pkg::PROD_W'(a) * buvt_pkg::PROD_W'(b);
	end

	assign p = p_q;
endmodule

// ===== tb/sv/box_union_volume_table_unit_checker.sv =====
// checker: predicts lit volume, box count and overflow flag per request and compares results
module box_union_volume_table_unit_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           pending_results,
	output int           overflow_seen,
	output int           results_seen
);
	typedef struct packed {
		logic [buvt_pkg::VOL_W-1:0] volume;
		logic [10:0]                count;
		logic                       over;
	} lit_result_t;

	buvt_pkg::box_t lit_table[$];
	lit_result_t    lit_expected[$];

	function automatic longint unsigned box_volume(buvt_pkg::box_t b);
		longint dx, dy, dz;
		dx = longint'(b.x1) - longint'(b.x0) + 1;
		dy = longint'(b.y1) - longint'(b.y0) + 1;
		dz = longint'(b.z1) - longint'(b.z0) + 1;
		return longint'(dx * dy * dz);
	endfunction

	function automatic lit_result_t apply_box(logic on, buvt_pkg::box_t b);
		buvt_pkg::box_t next_table[$];
		buvt_pkg::box_t a, f;
		lit_result_t    r;
		logic           empty, over;
		longint unsigned vol;
		logic signed [buvt_pkg::COORD_BITS-1:0] ix0, ix1, iy0, iy1, iz0, iz1;
		empty = (b.x0 > b.x1) || (b.y0 > b.y1) || (b.z0 > b.z1);
		over = 1'b0;
		vol = 0;
		foreach (lit_table[i]) begin
			a = lit_table[i];
			ix0 = (a.x0 > b.x0) ? a.x0 : b.x0;
			ix1 = (a.x1 < b.x1) ? a.x1 : b.x1;
			iy0 = (a.y0 > b.y0) ? a.y0 : b.y0;
			iy1 = (a.y1 < b.y1) ? a.y1 : b.y1;
			iz0 = (a.z0 > b.z0) ? a.z0 : b.z0;
			iz1 = (a.z1 < b.z1) ? a.z1 : b.z1;
			if (empty || ix0 > ix1 || iy0 > iy1 || iz0 > iz1) begin
				next_table.push_back(a);
				continue;
			end
			// cut along x, then y inside the x overlap, then z inside both
			if (a.x0 < ix0) begin
				f = a; f.x1 = buvt_pkg::COORD_BITS'(ix0 - 1); next_table.push_back(f);
			end
			if (ix1 < a.x1) begin
				f = a; f.x0 = buvt_pkg::COORD_BITS'(ix1 + 1); next_table.push_back(f);
			end
			if (a.y0 < iy0) begin
				f = a; f.x0 = ix0; f.x1 = ix1; f.y1 = buvt_pkg::COORD_BITS'(iy0 - 1);
				next_table.push_back(f);
			end
			if (iy1 < a.y1) begin
				f = a; f.x0 = ix0; f.x1 = ix1; f.y0 = buvt_pkg::COORD_BITS'(iy1 + 1);
				next_table.push_back(f);
			end
			if (a.z0 < iz0) begin
				f = a; f.x0 = ix0; f.x1 = ix1; f.y0 = iy0; f.y1 = iy1;
				f.z1 = buvt_pkg::COORD_BITS'(iz0 - 1);
				next_table.push_back(f);
			end
			if (iz1 < a.z1) begin
				f = a; f.x0 = ix0; f.x1 = ix1; f.y0 = iy0; f.y1 = iy1;
				f.z0 = buvt_pkg::COORD_BITS'(iz1 + 1);
				next_table.push_back(f);
			end
		end
		if (on && !empty) next_table.push_back(b);
		if (next_table.size() > buvt_pkg::MAX_BOXES) over = 1'b1;
		else lit_table = next_table;
		foreach (lit_table[i]) vol += box_volume(lit_table[i]);
		r.volume = vol[buvt_pkg::VOL_W-1:0];
		r.count = 11'(lit_table.size());
		r.over = over;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lit_result_t    want, got;
		buvt_pkg::box_t b;
		if (!arst_n) begin
			fail_count <= 0;
			overflow_seen <= 0;
			results_seen <= 0;
			pending_results <= 0;
			lit_table.delete();
			lit_expected.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				b.x0 = s_tdata[17:0];   b.x1 = s_tdata[35:18];
				b.y0 = s_tdata[53:36];  b.y1 = s_tdata[71:54];
				b.z0 = s_tdata[89:72];  b.z1 = s_tdata[107:90];
				lit_expected.push_back(apply_box(s_tuser, b));
			end
			if (m_tvalid && m_tready) begin
				got.volume = m_tdata[54:0];
				got.count = m_tdata[65:55];
				got.over = m_tuser;
				results_seen <= results_seen + 1;
				if (got.over) overflow_seen <= overflow_seen + 1;
				if (lit_expected.size() == 0) begin
					$display("%0t: unexpected result vol=%0d boxes=%0d over=%0b",
						$time, got.volume, got.count, got.over);
					fail_count <= fail_count + 1;
				end else begin
					want = lit_expected.pop_front();
					if (want !== got) begin
						$display("%0t: exp vol=%0d boxes=%0d over=%0b got vol=%0d boxes=%0d over=%0b",
							$time, want.volume, want.count, want.over,
							got.volume, got.count, got.over);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending_results <= lit_expected.size();
		end
	end
endmodule

// ===== tb/sv/box_union_volume_table_unit_tb.sv =====
// testbench top: drives box requests, stalls the result side, gives the verdict
module box_union_volume_table_unit_tb;
	localparam longint CYCLE_LIMIT = 64'd40_000_000;
	localparam int RANDOM_ITEMS = 240;
	localparam int QUIET_TAIL = 40;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic         m_tuser;
	int           fail_count, pending_results, overflow_seen, results_seen;
	longint       cycle_count = 0;
	bit           quiet = 1'b0;
	int           requests_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	box_union_volume_table_unit dut (.*);

	box_union_volume_table_unit_checker check (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side stalls in bursts until the quiet tail
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 17);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_box(logic on, int x0, x1, y0, y1, z0, z1);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= on;
		s_tdata <= {4'b0, 18'(z1), 18'(z0), 18'(y1), 18'(y0),
			18'(x1), 18'(x0)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
	endtask

	// centered box of random size, mostly small so the table fragments
	task automatic send_random_box(int span, int reach);
		int cx, cy, cz, hx, hy, hz;
		cx = $urandom_range(0, 2 * reach) - reach;
		cy = $urandom_range(0, 2 * reach) - reach;
		cz = $urandom_range(0, 2 * reach) - reach;
		hx = $urandom_range(0, span);
		hy = $urandom_range(0, span);
		hz = $urandom_range(0, span);
		send_box($urandom_range(0, 2) != 0, cx - hx, cx + hx, cy - hy, cy + hy,
			cz - hz, cz + hz);
	endtask

	initial begin
		int lo, hi;
		lo = -131072;
		hi = 131071;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, clear on empty table, empty boxes, splits on each axis
		send_box(1'b0, -5, 5, -5, 5, -5, 5);
		send_box(1'b1, lo, hi, lo, hi, lo, hi);
		send_box(1'b0, -1, 1, -2, 2, -3, 3);
		send_box(1'b1, 0, 0, 0, 0, 0, 0);
		send_box(1'b0, lo, hi, lo, hi, lo, hi);
		send_box(1'b1, 10, 20, 10, 20, 10, 20);
		send_box(1'b1, 15, 25, 12, 18, 5, 30);
		send_box(1'b0, 12, 12, 0, 30, 0, 30);
		send_box(1'b0, 0, 30, 14, 14, 0, 30);
		send_box(1'b0, 0, 30, 0, 30, 16, 16);
		send_box(1'b1, 5, 4, 0, 9, 0, 9);
		send_box(1'b0, 0, 9, 9, 0, 0, 9);
		send_box(1'b1, 0, 9, 0, 9, 3, 2);
		send_box(1'b1, hi, hi, hi, hi, hi, hi);
		send_box(1'b1, lo, lo, lo, lo, lo, lo);
		send_box(1'b1, -3, 3, -3, 3, -3, 3);
		send_box(1'b1, 10, 20, 10, 20, 10, 20);
		send_box(1'b0, -100, 100, -100, 100, -100, 100);
		// hold off until the table is settled and every result is back
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		// random: dense small boxes, some wide ones, a few full-range
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
			case ($urandom_range(0, 19))
				0: send_box(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
				1, 2: send_random_box(40, 60);
				default: send_random_box(6, 12);
			endcase
		end
		// clear, light one cube, then carve it with planes on each axis;
		// the grid of pieces grows past capacity during the z planes
		send_box(1'b0, lo, hi, lo, hi, lo, hi);
		send_box(1'b1, -20, 20, -20, 20, -20, 20);
		for (int i = 0; i < 10; i++) send_box(1'b0, -18 + 4 * i, -18 + 4 * i, lo, hi, lo, hi);
		for (int i = 0; i < 10; i++) send_box(1'b0, lo, hi, -18 + 4 * i, -18 + 4 * i, lo, hi);
		for (int i = 0; i < 10; i++) send_box(1'b0, lo, hi, lo, hi, -18 + 4 * i, -18 + 4 * i);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (20000) @(posedge clk);
		$display("sent %0d box requests, %0d results checked, %0d overflow results",
			requests_sent, results_seen, overflow_seen);
		if (fail_count == 0 && pending_results == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/buvt_pkg.sv
sv/buvt_store.sv
sv/buvt_frag.sv
sv/buvt_mul.sv
sv/box_union_volume_table_unit.sv
tb/sv/box_union_volume_table_unit_checker.sv
tb/sv/box_union_volume_table_unit_tb.sv
